[hw/rtl/obe_pkg.sv]
// Shared types and constants for the order book engine.
// Used by obe_ctrl, obe_dp and order_book_engine; depends on nothing.
package obe_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned PRICE_BITS_DEF = 32;

  // Input item packing (tdata), lowest bit first
  localparam int unsigned KEY_LSB    = 0;
  localparam int unsigned SIDE_BIT   = 32;
  localparam int unsigned PRICE_LSB  = 33;
  localparam int unsigned QTY_LSB    = 65;
  localparam int unsigned LVL_LSB    = 96;
  localparam int unsigned IN_TDATA_W = 104;
  localparam int unsigned REQ_W      = 3;

  // Result item packing
  localparam int unsigned OUT_PRICE_W = 32;
  localparam int unsigned SIZE_W      = 37;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned ST_W        = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 3'd0,
    REQ_MOD   = 3'd1,
    REQ_REM   = 3'd2,
    REQ_PRICE = 3'd3,
    REQ_SIZE  = 3'd4
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_LEVEL = 2'd3
  } st_e;

  typedef enum logic [1:0] {
    OP_MOD   = 2'd0,
    OP_FIND  = 2'd1,
    OP_SHIFT = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MOD,
    S_FIND,
    S_SHIFT,
    S_QSCAN,
    S_QEVAL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic latch;
    logic add;
    logic pass_start;
    op_e  pass_op;
    logic q_init;
    logic q_next;
    logic count_dec;
    logic set_st;
    st_e  st;
    logic publish;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic full;
    logic found;
    logic lvl_zero;
    logic lvl_bad;
    logic lvl_hit;
    logic pass_done;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/obe_dp.sv]
// Datapath of the order book engine: order table memory, scan sequencer,
// ranking accumulators and result register. Depends on obe_pkg.
module obe_dp import obe_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [REQ_W-1:0]       s_tuser_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  output logic [ST_W-1:0]        m_tuser_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned EW   = PRICE_BITS + 64;
  localparam int unsigned CMPW = (CW + 1 > 7) ? CW + 1 : 7;

  // Request held for the whole operation
  req_e                  req_q;
  logic [31:0]           key_q;
  logic                  side_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [30:0]           qty_q;
  logic [6:0]            level_q;
  logic [PRICE_BITS+31:0] price_ext;

  assign price_ext = {{PRICE_BITS{1'b0}}, s_tdata_i[PRICE_LSB +: 32]};

  // Table and scan sequencer
  logic [EW-1:0] mem_q [CAPACITY];
  logic [EW-1:0] rdata_q;
  logic [CW-1:0] count_q, ptr_q;
  logic [AW-1:0] raddr_q, loc_q;
  logic          busy_q, rvld_q, issue, pass_done, full;
  op_e           op_q;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [EW-1:0]         wdata;

  logic [30:0]           e_size;
  logic [PRICE_BITS-1:0] e_price;
  logic                  e_side;
  logic [31:0]           e_key;

  assign e_size  = rdata_q[30:0];
  assign e_price = rdata_q[PRICE_BITS+30:31];
  assign e_side  = rdata_q[PRICE_BITS+31];
  assign e_key   = rdata_q[PRICE_BITS+63:PRICE_BITS+32];

  assign issue     = busy_q && (ptr_q < count_q);
  assign pass_done = busy_q && !issue && !rvld_q;
  assign full      = (count_q == CW'(CAPACITY));

  // Ranking accumulators
  logic [CW-1:0]         side_cnt_q, cnt_q, cum_q;
  logic [PRICE_BITS-1:0] cand_q, thr_q;
  logic                  cand_vld_q, has_thr_q, found_q;
  logic [SIZE_W-1:0]     sum_q;
  st_e                   st_q;
  logic                  qual, better, same;

  function automatic logic ahead(input logic s, input logic [PRICE_BITS-1:0] a,
                                 input logic [PRICE_BITS-1:0] b);
    return s ? (a < b) : (a > b);
  endfunction

  assign qual   = !has_thr_q || ahead(side_q, thr_q, e_price);
  assign better = !cand_vld_q || ahead(side_q, e_price, cand_q);
  assign same   = (e_price == cand_q);

  // Select the single memory write of this cycle
  always_comb begin
    we    = 1'b0;
    waddr = raddr_q;
    wdata = rdata_q;
    if (cmd_i.add && !full) begin
      we    = 1'b1;
      waddr = count_q[AW-1:0];
      wdata = {key_q, side_q, price_q, qty_q};
    end else if (rvld_q && op_q == OP_MOD && e_key == key_q) begin
      we    = 1'b1;
      wdata = {rdata_q[EW-1:31], qty_q};
    end else if (rvld_q && op_q == OP_SHIFT) begin
      we    = 1'b1;
      waddr = raddr_q - AW'(1);
    end
  end

  // Table memory with registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (issue) begin
      rdata_q <= mem_q[ptr_q[AW-1:0]];
      raddr_q <= ptr_q[AW-1:0];
    end
  end

  // Sequence the scan and keep the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rvld_q  <= 1'b0;
      ptr_q   <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.pass_start) begin
        busy_q <= 1'b1;
        rvld_q <= 1'b0;
        ptr_q  <= (cmd_i.pass_op == OP_SHIFT) ? CW'(loc_q) + CW'(1) : '0;
      end else begin
        rvld_q <= issue;
        if (issue) ptr_q <= ptr_q + CW'(1);
        if (pass_done) busy_q <= 1'b0;
      end
      if (cmd_i.add && !full) count_q <= count_q + CW'(1);
      else if (cmd_i.count_dec) count_q <= count_q - CW'(1);
    end
  end

  // Capture the request and accumulate over each scanned entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= req_e'(s_tuser_i);
      key_q   <= s_tdata_i[KEY_LSB +: 32];
      side_q  <= s_tdata_i[SIDE_BIT];
      price_q <= price_ext[PRICE_BITS-1:0];
      qty_q   <= s_tdata_i[QTY_LSB +: 31];
      level_q <= s_tdata_i[LVL_LSB +: 7];
    end
    if (cmd_i.q_init) begin
      cum_q     <= '0;
      has_thr_q <= 1'b0;
    end
    if (cmd_i.q_next) begin
      cum_q     <= cum_q + cnt_q;
      thr_q     <= cand_q;
      has_thr_q <= 1'b1;
    end
    if (cmd_i.set_st) st_q <= cmd_i.st;
    if (cmd_i.pass_start) begin
      op_q       <= cmd_i.pass_op;
      found_q    <= 1'b0;
      side_cnt_q <= '0;
      cand_vld_q <= 1'b0;
      cnt_q      <= '0;
      sum_q      <= '0;
    end else if (rvld_q) begin
      case (op_q)
        OP_MOD: begin
          if (e_key == key_q) found_q <= 1'b1;
        end
        OP_FIND: begin
          if (e_key == key_q) begin
            found_q <= 1'b1;
            loc_q   <= raddr_q;
          end
        end
        OP_QUERY: begin
          if (e_side == side_q) begin
            side_cnt_q <= side_cnt_q + CW'(1);
            if (qual && better) begin
              cand_q     <= e_price;
              cand_vld_q <= 1'b1;
              cnt_q      <= CW'(1);
              sum_q      <= SIZE_W'(e_size);
            end else if (qual && same) begin
              cnt_q <= cnt_q + CW'(1);
              sum_q <= sum_q + SIZE_W'(e_size);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  logic                   out_vld_q;
  logic [ST_W-1:0]        out_st_q;
  logic [OUT_PRICE_W-1:0] out_price_q;
  logic [SIZE_W-1:0]      out_size_q;
  logic [PRICE_BITS+31:0] cand_ext;
  logic                   is_query, st_ok;

  assign cand_ext = {32'b0, cand_q};
  assign is_query = (req_q == REQ_PRICE) || (req_q == REQ_SIZE);
  assign st_ok    = (st_q == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_st_q    <= st_q;
      out_price_q <= (is_query && st_ok) ? cand_ext[OUT_PRICE_W-1:0] : '0;
      out_size_q  <= (req_q == REQ_SIZE && st_ok) ? sum_q : '0;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tuser_o  = out_st_q;
  assign m_tdata_o  = {3'b000, out_size_q, out_price_q};

  // Status towards the controller
  always_comb begin
    sts_o.req       = req_q;
    sts_o.full      = full;
    sts_o.found     = found_q;
    sts_o.lvl_zero  = (level_q == 7'd0);
    sts_o.lvl_bad   = CMPW'(level_q) > CMPW'(side_cnt_q);
    sts_o.lvl_hit   = CMPW'(level_q) <= (CMPW'(cum_q) + CMPW'(cnt_q));
    sts_o.pass_done = pass_done;
    sts_o.out_free  = !out_vld_q || m_tready_i;
  end

endmodule

[hw/rtl/obe_ctrl.sv]
// Controller of the order book engine: sequences each request through
// table scans and result publication. Depends on obe_pkg.
module obe_ctrl import obe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (s_tvalid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (sts_i.req)
          REQ_MOD:             state_d = S_MOD;
          REQ_REM:             state_d = S_FIND;
          REQ_PRICE, REQ_SIZE: state_d = sts_i.lvl_zero ? S_RESP : S_QSCAN;
          default:             state_d = S_RESP;
        endcase
      end
      S_MOD:   if (sts_i.pass_done) state_d = S_RESP;
      S_FIND:  if (sts_i.pass_done) state_d = sts_i.found ? S_SHIFT : S_RESP;
      S_SHIFT: if (sts_i.pass_done) state_d = S_RESP;
      S_QSCAN: if (sts_i.pass_done) state_d = S_QEVAL;
      S_QEVAL: state_d = (sts_i.lvl_bad || sts_i.lvl_hit) ? S_RESP : S_QSCAN;
      S_RESP:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.pass_op = OP_MOD;
    cmd_o.st      = ST_OK;
    s_tready_o    = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: cmd_o.latch = s_tvalid_i;
      S_DISPATCH: begin
        case (sts_i.req)
          REQ_ADD: begin
            cmd_o.add    = 1'b1;
            cmd_o.set_st = 1'b1;
            cmd_o.st     = sts_i.full ? ST_FULL : ST_OK;
          end
          REQ_MOD: begin
            cmd_o.pass_start = 1'b1;
            cmd_o.pass_op    = OP_MOD;
          end
          REQ_REM: begin
            cmd_o.pass_start = 1'b1;
            cmd_o.pass_op    = OP_FIND;
          end
          REQ_PRICE, REQ_SIZE: begin
            if (sts_i.lvl_zero) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_BAD_LEVEL;
            end else begin
              cmd_o.pass_start = 1'b1;
              cmd_o.pass_op    = OP_QUERY;
              cmd_o.q_init     = 1'b1;
            end
          end
          default: cmd_o.set_st = 1'b1;
        endcase
      end
      S_MOD: begin
        if (sts_i.pass_done) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = sts_i.found ? ST_OK : ST_NOT_FOUND;
        end
      end
      S_FIND: begin
        if (sts_i.pass_done) begin
          if (sts_i.found) begin
            cmd_o.pass_start = 1'b1;
            cmd_o.pass_op    = OP_SHIFT;
          end else begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_NOT_FOUND;
          end
        end
      end
      S_SHIFT: begin
        if (sts_i.pass_done) begin
          cmd_o.count_dec = 1'b1;
          cmd_o.set_st    = 1'b1;
        end
      end
      S_QEVAL: begin
        if (sts_i.lvl_bad) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_BAD_LEVEL;
        end else if (sts_i.lvl_hit) begin
          cmd_o.set_st = 1'b1;
        end else begin
          // advance to the next distinct price
          cmd_o.q_next     = 1'b1;
          cmd_o.pass_start = 1'b1;
          cmd_o.pass_op    = OP_QUERY;
        end
      end
      S_RESP: cmd_o.publish = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

[hw/rtl/order_book_engine.sv]
// Order book engine top level: stream ports, controller and datapath.
// Depends on obe_pkg, obe_ctrl and obe_dp.
//
// One request item enters on the s_axis group and exactly one result item
// leaves on the m_axis group. Requests: add, modify size, remove, price at
// level and size at level (tuser carries the request code).
// Items are handled one at a time; s_axis_tready_o is high only while the
// engine waits for a request. A finished result sits in an output register,
// so the next request is taken while that result still waits.
// Work per request, with N resting orders:
//   add and unused codes: dispatch, then straight to the output register.
//   modify: one table scan over the N entries, one memory read per cycle.
//   remove: two scans, a search and a shift of the later entries.
//   queries: one scan per distinct price from the best down to the one
//   asked for.
// During a scan the table memory is read once per cycle.
// Reset empties the table at once (fill count to zero) and drops any
// pending result. When the receiver stalls, the result holds in the output
// register and the engine stops before publishing the next one.
module order_book_engine import obe_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // order_key[31:0], book_side[32], limit_price[64:33], quantity[95:65],
  // depth_level[102:96], zero[103]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // req_type[2:0]
  input  logic [REQ_W-1:0]       s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // price_out[31:0], size_out[68:32], zero[71:69]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status[1:0]
  output logic [ST_W-1:0]        m_axis_tuser_o
);

  cmd_t cmd;
  sts_t sts;

  obe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  obe_dp #(
    .CAPACITY   (CAPACITY),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

  // An accepted item closes the input until its result is published
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a request is in progress");

  // Publishing never overwrites a result that is still waiting
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> sts.out_free)
    else $error("result published over a pending item");

  // A result appears only after the controller publishes it
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cmd.publish))
    else $error("result valid without publish");

endmodule
